[rtl/pds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants for the position deque store
// Entry layout, command and status codes, and the control structs that run
// along the row of storage cells.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COORD_W  = 8;
	localparam int RIDX_W   = 8;
	localparam int SIZE_W   = 9;
	localparam int CMP_W    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_READ     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] symbol;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} entry_t;

	// broadcast to every cell for one cycle when a command is taken
	typedef struct packed {
		logic             ins_head;
		logic             ins_tail;
		logic             rem_head;
		logic [IDX_W-1:0] tail_pos;
		entry_t           entry;
	} cell_ctrl_t;

	// read probe walking the row, one cell per cycle
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		entry_t           entry;
	} probe_t;

endpackage
`default_nettype wire

[rtl/pds_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_cell: one storage cell of the deque row
// Holds the entry at one list position, shifts with its neighbors on head
// insert and head remove, and passes the read probe on to the next cell.
// ----------------------------------------------------------------------------
module pds_cell (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire logic [pds_pkg::IDX_W-1:0]     cell_index,
	input  wire pds_pkg::cell_ctrl_t           ctrl,
	input  wire pds_pkg::entry_t               prev_entry,
	input  wire pds_pkg::entry_t               next_entry,
	input  wire pds_pkg::probe_t               probe_in,
	output pds_pkg::entry_t                    entry_out,
	output pds_pkg::probe_t                    probe_out
);

	pds_pkg::entry_t entry_q;
	logic            probe_vld_q;
	logic [pds_pkg::IDX_W-1:0] probe_idx_q;
	pds_pkg::entry_t probe_entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_head) begin
			entry_q <= prev_entry;
		end else if (ctrl.rem_head) begin
			entry_q <= next_entry;
		end else if (ctrl.ins_tail && (ctrl.tail_pos == cell_index)) begin
			entry_q <= ctrl.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_vld_q <= 1'b0;
		end else begin
			probe_vld_q <= probe_in.vld;
		end
	end

	// the matching cell drops its entry into the probe
	always_ff @(posedge clk) begin
		probe_idx_q <= probe_in.idx;
		if (probe_in.vld && (probe_in.idx == cell_index)) begin
			probe_entry_q <= entry_q;
		end else begin
			probe_entry_q <= probe_in.entry;
		end
	end

	assign entry_out       = entry_q;
	assign probe_out.vld   = probe_vld_q;
	assign probe_out.idx   = probe_idx_q;
	assign probe_out.entry = probe_entry_q;

endmodule
`default_nettype wire

[rtl/pds_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl: command decode, size tracking and result register
// Decodes each item, keeps the entry count, drives the cell row and holds
// the result until the output side takes it.
// ----------------------------------------------------------------------------
module pds_ctrl (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire pds_pkg::cmd_t                  command,
	input  wire pds_pkg::entry_t                in_entry,
	input  wire logic [pds_pkg::RIDX_W-1:0]     read_index,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output pds_pkg::entry_t                     out_entry,
	output logic [pds_pkg::SIZE_W-1:0]          list_size,
	output pds_pkg::status_t                    status,
	output pds_pkg::cell_ctrl_t                 cell_ctrl,
	output pds_pkg::probe_t                     probe_launch,
	input  wire pds_pkg::probe_t                probe_return
);

	pds_pkg::state_t state_q, state_d;
	logic [pds_pkg::CNT_W-1:0] count_q, count_d;
	logic                      out_vld_q;
	pds_pkg::entry_t           out_entry_q;
	logic [pds_pkg::SIZE_W-1:0] out_size_q;
	pds_pkg::status_t          out_status_q;

	logic                      accept;
	logic                      full, empty, in_range, launch, load;
	logic [pds_pkg::CMP_W-1:0] idx_ext, cnt_ext;
	pds_pkg::status_t          sts_d;
	pds_pkg::entry_t           load_entry;
	pds_pkg::status_t          load_status;
	logic [pds_pkg::CNT_W-1:0] load_size;

	assign in_ready = (state_q == pds_pkg::ST_IDLE) && (!out_vld_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == pds_pkg::CNT_W'(pds_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign idx_ext  = pds_pkg::CMP_W'(read_index);
	assign cnt_ext  = pds_pkg::CMP_W'(count_q);
	assign in_range = (idx_ext < cnt_ext);

	always_comb begin
		cell_ctrl          = '0;
		cell_ctrl.tail_pos = count_q[pds_pkg::IDX_W-1:0];
		cell_ctrl.entry    = in_entry;
		count_d            = count_q;
		sts_d              = pds_pkg::STS_OK;
		launch             = 1'b0;
		if (accept) begin
			case (command)
				pds_pkg::CMD_INS_HEAD, pds_pkg::CMD_INS_TAIL: begin
					if (full) begin
						sts_d = pds_pkg::STS_FULL;
					end else begin
						cell_ctrl.ins_head = (command == pds_pkg::CMD_INS_HEAD);
						cell_ctrl.ins_tail = (command == pds_pkg::CMD_INS_TAIL);
						count_d = count_q + 1'b1;
					end
				end
				pds_pkg::CMD_REM_HEAD, pds_pkg::CMD_REM_TAIL: begin
					if (empty) begin
						sts_d = pds_pkg::STS_EMPTY;
					end else begin
						cell_ctrl.rem_head = (command == pds_pkg::CMD_REM_HEAD);
						count_d = count_q - 1'b1;
					end
				end
				pds_pkg::CMD_READ: begin
					if (in_range) begin
						launch = 1'b1;
					end else begin
						sts_d = pds_pkg::STS_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign probe_launch.vld   = launch;
	assign probe_launch.idx   = idx_ext[pds_pkg::IDX_W-1:0];
	assign probe_launch.entry = '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pds_pkg::ST_IDLE: begin
				if (launch) begin
					state_d = pds_pkg::ST_READ;
				end
			end
			pds_pkg::ST_READ: begin
				if (probe_return.vld) begin
					state_d = pds_pkg::ST_IDLE;
				end
			end
			default: state_d = pds_pkg::ST_IDLE;
		endcase
	end

	// result load
	always_comb begin
		load        = 1'b0;
		load_entry  = '0;
		load_status = sts_d;
		load_size   = count_d;
		case (state_q)
			pds_pkg::ST_IDLE: begin
				load = accept && !launch;
			end
			pds_pkg::ST_READ: begin
				load        = probe_return.vld;
				load_entry  = probe_return.entry;
				load_status = pds_pkg::STS_OK;
				load_size   = count_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pds_pkg::ST_IDLE;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_entry_q  <= load_entry;
			out_size_q   <= pds_pkg::SIZE_W'(load_size);
			out_status_q <= load_status;
		end
	end

	assign out_valid = out_vld_q;
	assign out_entry = out_entry_q;
	assign list_size = out_size_q;
	assign status    = out_status_q;

endmodule
`default_nettype wire

[rtl/position_deque_store_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// position_deque_store_core: bounded deque of board positions
// Inserts, removes and indexed reads on a row of shifting storage cells.
// Inserts, removes, out-of-range reads: result in the cycle after the item,
//   one item per cycle while results are taken. In-range reads: the probe
//   walks the whole cell row; no new item is taken while it walks.
// Reset: asynchronous, clears the size, the probe valid bits and the output
//   valid flag; cell contents are undefined until written.
// ----------------------------------------------------------------------------
module position_deque_store_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// command[2:0], in_x[10:3], in_y[18:11], in_symbol[26:19],
	// read_index[34:27], zero[39:35]
	input  wire  [39:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// out_x[7:0], out_y[15:8], out_symbol[23:16], list_size[32:24],
	// status[34:33], zero[39:35]
	output logic [39:0]  m_tdata
);

	pds_pkg::entry_t     in_entry;
	pds_pkg::entry_t     out_entry;
	pds_pkg::cmd_t       command;
	logic [pds_pkg::SIZE_W-1:0] list_size;
	pds_pkg::status_t    status;
	pds_pkg::cell_ctrl_t cell_ctrl;
	pds_pkg::probe_t     probe_chain [pds_pkg::CAPACITY+1];
	pds_pkg::entry_t     entry_row   [pds_pkg::CAPACITY];

	assign command         = pds_pkg::cmd_t'(s_tdata[2:0]);
	assign in_entry.x      = s_tdata[10:3];
	assign in_entry.y      = s_tdata[18:11];
	assign in_entry.symbol = s_tdata[26:19];

	pds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.command      (command),
		.in_entry     (in_entry),
		.read_index   (s_tdata[34:27]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_entry    (out_entry),
		.list_size    (list_size),
		.status       (status),
		.cell_ctrl    (cell_ctrl),
		.probe_launch (probe_chain[0]),
		.probe_return (probe_chain[pds_pkg::CAPACITY])
	);

	for (genvar k = 0; k < pds_pkg::CAPACITY; k++) begin : g_cell
		pds_pkg::entry_t prev_e, next_e;
		// head cell takes the new entry on head insert; last cell keeps itself
		if (k == 0) begin : g_first
			assign prev_e = cell_ctrl.entry;
		end else begin : g_mid
			assign prev_e = entry_row[k-1];
		end
		if (k == pds_pkg::CAPACITY - 1) begin : g_last
			assign next_e = entry_row[k];
		end else begin : g_body
			assign next_e = entry_row[k+1];
		end

		pds_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (pds_pkg::IDX_W'(k)),
			.ctrl       (cell_ctrl),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.probe_in   (probe_chain[k]),
			.entry_out  (entry_row[k]),
			.probe_out  (probe_chain[k+1])
		);
	end

	assign m_tdata = {5'd0, status, list_size, out_entry.symbol, out_entry.y, out_entry.x};

endmodule
`default_nettype wire
